FILE: design/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_TOTAL     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RLE_MODE        = 2'd2;

  localparam logic [2:0]  BPP_RGB        = 3'd3;
  localparam logic [2:0]  BPP_RGBA       = 3'd4;
  localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

  localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
  localparam logic [7:0] RUN_OFFSET     = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic       overflow_error;
  } pixel_t;

endpackage

FILE: design/tgarle_in_reg.sv
// Input register that holds one accepted byte beat until the decoder takes it.
module tgarle_in_reg
  import tgarle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_beat,
  input  logic     advance,
  output logic     beat_valid,
  output in_beat_t beat
);

  logic load;

  assign in_stall = beat_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= in_beat;
    end
  end

endmodule

FILE: design/tgarle_core.sv
// Configuration registers, packet state and per-byte pixel decode.
module tgarle_core
  import tgarle_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      beat_valid,
  input  in_beat_t                  beat,
  input  logic                      out_ready,
  output logic                      advance,
  output logic                      emit,
  output pixel_t                    res
);

  localparam int PCB = PIXEL_COUNT_BITS;

  logic [2:0]  bytes_per_pixel;
  logic [31:0] pixel_total;
  logic        rle_mode;

  logic           expect_header, expect_header_next;
  logic           run_packet, run_packet_next;
  logic [7:0]     raw_pixels_left, raw_pixels_left_next;
  logic [7:0]     run_length, run_length_next;
  logic [1:0]     byte_position, byte_position_next;
  logic [PCB-1:0] pixels_done, pixels_done_next;
  logic           sticky_error, sticky_error_next;
  logic [7:0]     colour_bytes [3];

  logic           exp_eff, run_eff, err_eff;
  logic [7:0]     raw_eff, runlen_eff;
  logic [1:0]     pos_eff, pos_last;
  logic [PCB-1:0] done_eff, total, remaining, count_ext;
  logic [7:0]     count, raw_dec;
  logic           bpp4, store, more_in_packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RGB;
      pixel_total     <= PIXEL_TOTAL_RST;
      rle_mode        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        CFG_PIXEL_TOTAL:     pixel_total     <= cfg_data[31:0];
        CFG_RLE_MODE:        rle_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Image start clears the image state before the byte is handled.
    exp_eff    = beat.image_start ? 1'b1 : expect_header;
    run_eff    = beat.image_start ? 1'b0 : run_packet;
    raw_eff    = beat.image_start ? 8'd0 : raw_pixels_left;
    runlen_eff = beat.image_start ? 8'd0 : run_length;
    pos_eff    = beat.image_start ? 2'd0 : byte_position;
    done_eff   = beat.image_start ? '0 : pixels_done;
    err_eff    = beat.image_start ? 1'b0 : sticky_error;

    total     = pixel_total[PCB-1:0];
    bpp4      = (bytes_per_pixel == BPP_RGBA);
    pos_last  = bpp4 ? 2'd3 : 2'd2;
    remaining = total - done_eff;
    raw_dec   = (raw_eff != 8'd0) ? raw_eff - 8'd1 : 8'd0;

    expect_header_next   = exp_eff;
    run_packet_next      = run_eff;
    raw_pixels_left_next = raw_eff;
    run_length_next      = runlen_eff;
    byte_position_next   = pos_eff;
    pixels_done_next     = done_eff;
    sticky_error_next    = err_eff;
    store                = 1'b0;
    emit                 = 1'b0;
    more_in_packet       = 1'b0;
    count                = 8'd1;
    count_ext            = '0;

    if (done_eff >= total) begin
      // Image complete: the byte is dropped.
    end else if (rle_mode && exp_eff) begin
      if (beat.data_byte < RUN_HEADER_MIN) begin
        run_packet_next      = 1'b0;
        raw_pixels_left_next = beat.data_byte + 8'd1;
      end else begin
        run_packet_next = 1'b1;
        run_length_next = beat.data_byte - RUN_OFFSET;
      end
      expect_header_next = 1'b0;
      byte_position_next = 2'd0;
    end else if (pos_eff < pos_last) begin
      store              = 1'b1;
      byte_position_next = pos_eff + 2'd1;
    end else begin
      emit               = 1'b1;
      byte_position_next = 2'd0;
      if (rle_mode) begin
        if (run_eff) begin
          count              = runlen_eff;
          expect_header_next = 1'b1;
        end else begin
          raw_pixels_left_next = raw_dec;
          if (raw_dec == 8'd0) begin
            expect_header_next = 1'b1;
          end else begin
            more_in_packet = 1'b1;
          end
        end
      end
      count_ext = {{(PCB-8){1'b0}}, count};
      if (count_ext > remaining) begin
        count             = remaining[7:0];
        count_ext         = remaining;
        sticky_error_next = 1'b1;
      end
      pixels_done_next = done_eff + count_ext;
      if (pixels_done_next == total && more_in_packet) begin
        sticky_error_next = 1'b1;
      end
    end

    res.blue           = colour_bytes[0];
    res.green          = colour_bytes[1];
    res.red            = bpp4 ? colour_bytes[2] : beat.data_byte;
    res.alpha          = bpp4 ? beat.data_byte : 8'd0;
    res.repeat_count   = count;
    res.last_pixel     = (pixels_done_next == total);
    res.overflow_error = sticky_error_next;

    // A beat that yields no pixel never waits for the result register.
    advance = beat_valid && (out_ready || !emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header   <= 1'b1;
      run_packet      <= 1'b0;
      raw_pixels_left <= 8'd0;
      run_length      <= 8'd0;
      byte_position   <= 2'd0;
      pixels_done     <= '0;
      sticky_error    <= 1'b0;
    end else if (advance) begin
      expect_header   <= expect_header_next;
      run_packet      <= run_packet_next;
      raw_pixels_left <= raw_pixels_left_next;
      run_length      <= run_length_next;
      byte_position   <= byte_position_next;
      pixels_done     <= pixels_done_next;
      sticky_error    <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store) begin
      case (pos_eff)
        2'd0:    colour_bytes[0] <= beat.data_byte;
        2'd1:    colour_bytes[1] <= beat.data_byte;
        default: colour_bytes[2] <= beat.data_byte;
      endcase
    end
  end

endmodule

FILE: design/tgarle_out_reg.sv
// Result register that holds one decoded pixel beat until downstream takes it.
module tgarle_out_reg
  import tgarle_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  pixel_t res,
  output logic   ready,
  output logic   out_valid,
  input  logic   out_stall,
  output pixel_t pixel
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      pixel <= res;
    end
  end

endmodule

FILE: design/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA run-length pixel decoder.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------------
//   in       | input     | in_valid / in_stall  | data_byte, image_start
//   out      | output    | out_valid / out_stall| red, green, blue, alpha, repeat_count,
//            |           |                      | last_pixel, overflow_error
//   cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// One byte beat is taken per cycle unless in_stall is raised; a pixel beat becomes valid once its last
// byte has passed the input register and been decoded into the result register.
// Throughput is one byte per cycle while no stall holds the flow; the decoder updates its state per byte.
// Reset is synchronous; it clears packet state, counters and both beat registers.
// A stalled result holds its register; bytes that yield no pixel still flow meanwhile.
module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                data_byte,
  input  logic                      image_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic [7:0]                alpha,
  output logic [7:0]                repeat_count,
  output logic                      last_pixel,
  output logic                      overflow_error
);

  in_beat_t in_beat, beat;
  pixel_t   res, pixel;
  logic     beat_valid, advance, emit, out_ready;

  assign in_beat.data_byte   = data_byte;
  assign in_beat.image_start = image_start;

  tgarle_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  tgarle_core #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_ready  (out_ready),
    .advance    (advance),
    .emit       (emit),
    .res        (res)
  );

  tgarle_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel)
  );

  assign red            = pixel.red;
  assign green          = pixel.green;
  assign blue           = pixel.blue;
  assign alpha          = pixel.alpha;
  assign repeat_count   = pixel.repeat_count;
  assign last_pixel     = pixel.last_pixel;
  assign overflow_error = pixel.overflow_error;

endmodule

FILE: design/tgarle_checker.sv
// Port-level checks for the TGA run-length pixel decoder, bound to its top level.
module tgarle_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] repeat_count,
  input logic       last_pixel,
  input logic       overflow_error
);

  // The result register is cleared by reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(red) && $stable(repeat_count)
      && $stable(last_pixel) && $stable(overflow_error))
    else $error("stalled result beat changed");

  // Every emitted pixel covers at least one image pixel, even when clipped.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 8'd0)
    else $error("result beat with zero repeat count");

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .red            (red),
  .repeat_count   (repeat_count),
  .last_pixel     (last_pixel),
  .overflow_error (overflow_error)
);
